FILE: rtl/lltok_pkg.sv
// Shared types, codes and constants of the Lisp line tokenizer.
`default_nettype none
package lltok_pkg;

  // Highest column: the smaller of the line length less one and 255.
  localparam int unsigned LineLength = 256;
  localparam int unsigned ColMaxInt  = (LineLength - 1 < 255) ? (LineLength - 1) : 255;
  localparam logic [7:0]  ColMax     = 8'(ColMaxInt);

  // Depth of the queue between scanner and token issue.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic [2:0] {
    KIND_OPEN_PAREN    = 3'd0,
    KIND_OPEN_BRACKET  = 3'd1,
    KIND_CLOSE_PAREN   = 3'd2,
    KIND_CLOSE_BRACKET = 3'd3,
    KIND_ATOM          = 3'd4,
    KIND_EOL           = 3'd5
  } token_kind_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_BAR       = 2'd1,
    ERR_STRING    = 2'd2
  } scan_error_e;

  localparam logic [7:0] ChNul       = 8'h00;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChOpenPar   = 8'h28;
  localparam logic [7:0] ChClosePar  = 8'h29;
  localparam logic [7:0] ChOpenBrk   = 8'h5B;
  localparam logic [7:0] ChCloseBrk  = 8'h5D;
  localparam logic [7:0] ChSemicolon = 8'h3B;
  localparam logic [7:0] ChBang      = 8'h21;
  localparam logic [7:0] ChBar       = 8'h7C;
  localparam logic [7:0] ChDquote    = 8'h22;
  localparam logic [7:0] ChQuote     = 8'h27;
  localparam logic [7:0] ChBackslash = 8'h5C;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] start;
    logic [7:0] stop;
    logic [1:0] err;
  } token_t;

  // Work for the issue side: one or two tokens caused by one character.
  typedef struct packed {
    logic   two;
    token_t tok0;
    token_t tok1;
  } job_t;

endpackage
`default_nettype wire

FILE: rtl/lltok_if.sv
// Channel interfaces: characters in, tokens out.
`default_nettype none
interface lltok_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

interface lltok_token_if;
  logic       valid;
  logic       ready;
  logic [2:0] token_kind;
  logic [7:0] token_start;
  logic [7:0] token_end;
  logic [1:0] scan_error;
  logic       last_of_run;

  modport source (output valid, output token_kind, output token_start, output token_end,
                  output scan_error, output last_of_run, input ready);
  modport sink (input valid, input token_kind, input token_start, input token_end,
                input scan_error, input last_of_run, output ready);
endinterface
`default_nettype wire

FILE: rtl/lisp_line_tokenizer_core.sv
// Top level of the Lisp line tokenizer: scanner, job queue and token issue.
// The first token of a character is held in the job queue and then in the output register before it is offered.
// Throughput: one character per cycle while the queue has room, and one token per cycle while the output is ready.
// A character that yields two tokens takes two output transfers; a four-job queue absorbs this.
// Reset (asynchronous, active low) puts the scanner between tokens at column 0
// and empties the queue and the output register.
`default_nettype none
module lisp_line_tokenizer_core (
  input  wire          clk_i,
  input  wire          rst_ni,
  lltok_char_if.sink   char_in,
  lltok_token_if.source token_out
);

  // The scanner moves on every accepted character; it only needs room in the
  // queue for a job, since at most one job is made per character.
  logic              q_ready;
  logic              accept;
  logic              push;
  lltok_pkg::job_t   push_job;
  logic              pop;
  logic              nonempty;
  lltok_pkg::job_t   head;
  lltok_pkg::token_t out_tok;
  logic              out_last;

  assign char_in.ready = q_ready;
  assign accept        = char_in.valid && q_ready;

  lltok_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .char_i   (char_in.char_code),
    .push_o   (push),
    .job_o    (push_job)
  );

  // The queue decouples the scanner from stalls on the token side.
  lltok_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .ready_o    (q_ready),
    .pop_i      (pop),
    .nonempty_o (nonempty),
    .head_o     (head)
  );

  // The issue side drives a registered output, so a waiting token never
  // blocks the scanner directly.
  lltok_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .nonempty_i  (nonempty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (token_out.valid),
    .out_ready_i (token_out.ready),
    .out_tok_o   (out_tok),
    .out_last_o  (out_last)
  );

  assign token_out.token_kind  = out_tok.kind;
  assign token_out.token_start = out_tok.start;
  assign token_out.token_end   = out_tok.stop;
  assign token_out.scan_error  = out_tok.err;
  assign token_out.last_of_run = out_last;

endmodule
`default_nettype wire

FILE: rtl/lltok_front.sv
// Scanner: tracks the lexical mode per character and forms token jobs.
`default_nettype none
module lltok_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 accept_i,
  input  wire  [7:0]          char_i,
  output logic                push_o,
  output lltok_pkg::job_t     job_o
);

  typedef enum logic [2:0] {
    M_BETWEEN = 3'd0,
    M_QUOTE   = 3'd1,
    M_BAR     = 3'd2,
    M_STRING  = 3'd3,
    M_PLAIN   = 3'd4,
    M_BANG    = 3'd5,
    M_COMMENT = 3'd6
  } mode_e;

  mode_e      mode_q, mode_d;
  logic [7:0] col_q, col_d;
  logic [7:0] ots_q, ots_d;
  logic       bs_q, bs_d;
  logic       over_q, over_d;

  logic [7:0]       prevcol;
  logic             is_paren, is_term;
  logic [2:0]       pk;
  logic             run_between;
  logic             a_v, b_v;
  lltok_pkg::token_t a_tok, b_tok;

  always_comb begin
    unique case (char_i)
      lltok_pkg::ChOpenPar:  begin is_paren = 1'b1; pk = lltok_pkg::KIND_OPEN_PAREN;    end
      lltok_pkg::ChOpenBrk:  begin is_paren = 1'b1; pk = lltok_pkg::KIND_OPEN_BRACKET;  end
      lltok_pkg::ChClosePar: begin is_paren = 1'b1; pk = lltok_pkg::KIND_CLOSE_PAREN;   end
      lltok_pkg::ChCloseBrk: begin is_paren = 1'b1; pk = lltok_pkg::KIND_CLOSE_BRACKET; end
      default:               begin is_paren = 1'b0; pk = lltok_pkg::KIND_ATOM;          end
    endcase
    is_term = is_paren || char_i == lltok_pkg::ChNul || char_i == lltok_pkg::ChSpace
              || char_i == lltok_pkg::ChSemicolon;
    prevcol = over_q ? lltok_pkg::ColMax : ((col_q != 8'd0) ? col_q - 8'd1 : 8'd0);
  end

  always_comb begin
    mode_d      = mode_q;
    ots_d       = ots_q;
    bs_d        = bs_q;
    run_between = 1'b0;
    a_v         = 1'b0;
    b_v         = 1'b0;
    a_tok       = '{kind: lltok_pkg::KIND_ATOM, start: ots_q, stop: prevcol,
                    err: lltok_pkg::ERR_NONE};
    b_tok       = '{kind: lltok_pkg::KIND_EOL, start: col_q, stop: col_q,
                    err: lltok_pkg::ERR_NONE};

    // An atom that closes on a terminator hands the same character to the
    // between-tokens rules.
    unique case (mode_q)
      M_QUOTE, M_PLAIN: begin
        if (mode_q == M_QUOTE && char_i == lltok_pkg::ChBar) begin
          mode_d = M_BAR;
          bs_d   = 1'b0;
        end else if (mode_q == M_QUOTE && char_i == lltok_pkg::ChDquote) begin
          mode_d = M_STRING;
          bs_d   = 1'b0;
        end else if (is_term) begin
          a_v         = 1'b1;
          mode_d      = M_BETWEEN;
          run_between = 1'b1;
        end else if (char_i == lltok_pkg::ChBang) begin
          mode_d = M_BANG;
        end else begin
          mode_d = M_PLAIN;
        end
      end
      M_BANG: begin
        if (char_i == lltok_pkg::ChNul) begin
          a_v         = 1'b1;
          run_between = 1'b1;
        end else begin
          mode_d = M_PLAIN;
        end
      end
      M_BAR: begin
        if (char_i == lltok_pkg::ChNul) begin
          a_v         = 1'b1;
          a_tok.err   = lltok_pkg::ERR_BAR;
          run_between = 1'b1;
        end else begin
          if (char_i == lltok_pkg::ChBar && !bs_q) mode_d = M_PLAIN;
          bs_d = (char_i == lltok_pkg::ChBackslash);
        end
      end
      M_STRING: begin
        if (char_i == lltok_pkg::ChNul) begin
          a_v         = 1'b1;
          a_tok.err   = lltok_pkg::ERR_STRING;
          run_between = 1'b1;
        end else if (char_i == lltok_pkg::ChDquote && !bs_q) begin
          a_v        = 1'b1;
          a_tok.stop = col_q;
          mode_d     = M_BETWEEN;
        end else begin
          bs_d = (char_i == lltok_pkg::ChBackslash);
        end
      end
      M_COMMENT: begin
        if (char_i == lltok_pkg::ChNul) begin
          b_v         = 1'b1;
          b_tok.start = ots_q;
          b_tok.stop  = ots_q;
        end
      end
      default: begin
        mode_d      = M_BETWEEN;
        run_between = 1'b1;
      end
    endcase

    if (run_between) begin
      priority if (char_i == lltok_pkg::ChNul) begin
        b_v = 1'b1;
      end else if (is_paren) begin
        b_v        = 1'b1;
        b_tok.kind = pk;
      end else if (char_i == lltok_pkg::ChSpace) begin
        mode_d = M_BETWEEN;
      end else if (char_i == lltok_pkg::ChSemicolon) begin
        mode_d = M_COMMENT;
        ots_d  = col_q;
      end else begin
        ots_d = col_q;
        bs_d  = 1'b0;
        priority if (char_i == lltok_pkg::ChQuote)  mode_d = M_QUOTE;
        else if (char_i == lltok_pkg::ChBar)        mode_d = M_BAR;
        else if (char_i == lltok_pkg::ChDquote)     mode_d = M_STRING;
        else if (char_i == lltok_pkg::ChBang)       mode_d = M_BANG;
        else                                        mode_d = M_PLAIN;
      end
    end

    col_d  = col_q;
    over_d = over_q;
    if (char_i == lltok_pkg::ChNul) begin
      mode_d = M_BETWEEN;
      col_d  = 8'd0;
      ots_d  = 8'd0;
      bs_d   = 1'b0;
      over_d = 1'b0;
    end else if (col_q < lltok_pkg::ColMax) begin
      col_d = col_q + 8'd1;
    end else begin
      over_d = 1'b1;
    end

    push_o = accept_i && (a_v || b_v);
    if (a_v) begin
      job_o.two  = b_v;
      job_o.tok0 = a_tok;
      job_o.tok1 = b_tok;
    end else begin
      job_o.two  = 1'b0;
      job_o.tok0 = b_tok;
      job_o.tok1 = b_tok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_BETWEEN;
      col_q  <= 8'd0;
      ots_q  <= 8'd0;
      bs_q   <= 1'b0;
      over_q <= 1'b0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      col_q  <= col_d;
      ots_q  <= ots_d;
      bs_q   <= bs_d;
      over_q <= over_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/lltok_queue.sv
// Short first-in first-out queue of token jobs.
`default_nettype none
module lltok_queue (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  lltok_pkg::job_t  push_job_i,
  output logic             ready_o,
  input  wire              pop_i,
  output logic             nonempty_o,
  output lltok_pkg::job_t  head_o
);

  lltok_pkg::job_t                     mem_q [lltok_pkg::QueueDepth];
  logic [lltok_pkg::QueuePtrW-1:0]     wr_q, rd_q;
  logic [lltok_pkg::QueueCntW-1:0]     cnt_q;
  logic                                do_push, do_pop;

  assign ready_o    = (cnt_q < lltok_pkg::QueueCntW'(lltok_pkg::QueueDepth));
  assign nonempty_o = (cnt_q != '0);
  assign head_o     = mem_q[rd_q];
  assign do_push    = push_i && ready_o;
  assign do_pop     = pop_i && nonempty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + lltok_pkg::QueuePtrW'(1);
      if (do_pop)  rd_q <= rd_q + lltok_pkg::QueuePtrW'(1);
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + lltok_pkg::QueueCntW'(1);
        2'b01:   cnt_q <= cnt_q - lltok_pkg::QueueCntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/lltok_back.sv
// Token issue: splits each job into one or two output transfers.
`default_nettype none
module lltok_back (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              nonempty_i,
  input  lltok_pkg::job_t  head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire              out_ready_i,
  output lltok_pkg::token_t out_tok_o,
  output logic             out_last_o
);

  logic              out_valid_q;
  lltok_pkg::token_t out_tok_q;
  logic              out_last_q;
  logic              pend_q;
  lltok_pkg::token_t pend_tok_q;
  logic              load;

  assign load        = !out_valid_q || out_ready_i;
  assign pop_o       = load && !pend_q && nonempty_i;
  assign out_valid_o = out_valid_q;
  assign out_tok_o   = out_tok_q;
  assign out_last_o  = out_last_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (pend_q) begin
        out_tok_q  <= pend_tok_q;
        out_last_q <= 1'b1;
      end else begin
        out_tok_q  <= head_i.tok0;
        out_last_q <= !head_i.two;
      end
    end
    if (pop_o) pend_tok_q <= head_i.tok1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else if (load) begin
      if (pend_q) begin
        out_valid_q <= 1'b1;
        pend_q      <= 1'b0;
      end else begin
        out_valid_q <= nonempty_i;
        pend_q      <= nonempty_i && head_i.two;
      end
    end
  end

endmodule
`default_nettype wire
